### rtl/glyph_text_blitter_macros.svh
// Assertion macros used by the blitter RTL.
`ifndef GLYPH_TEXT_BLITTER_MACROS_SVH
`define GLYPH_TEXT_BLITTER_MACROS_SVH

// Checked property that is ignored while reset is held.
`define GTB_ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds during reset.
`define GTB_ASSERT(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/gtb_pkg.sv
package gtb_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FB_WIDTH    = 3'd0;
  localparam logic [2:0] CFG_FB_HEIGHT   = 3'd1;
  localparam logic [2:0] CFG_LINE_STRIDE = 3'd2;
  localparam logic [2:0] CFG_GLYPH_COLS  = 3'd3;
  localparam logic [2:0] CFG_GLYPH_ROWS  = 3'd4;

  // Request kinds.
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_RENDER = 1'b1;

  // At most this many rows are emitted per character.
  localparam int ROW_LIMIT = 16;
  localparam int GLYPH_BITS = 8;
  localparam logic [7:0] LEFT_BIT = 8'h80;

  localparam logic [15:0] RST_FB_WIDTH    = 16'd320;
  localparam logic [15:0] RST_FB_HEIGHT   = 16'd240;
  localparam logic [15:0] RST_LINE_STRIDE = 16'd320;
  localparam logic [3:0]  RST_GLYPH_COLS  = 4'd8;
  localparam logic [4:0]  RST_GLYPH_ROWS  = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_ISSUE = 2'b10
  } state_t;

  // Row in flight between the fetch and the multiply stage.
  typedef struct packed {
    logic        valid;
    logic [15:0] y;
    logic        last;
    logic        blank;
  } fetch_stage_t;

endpackage

### rtl/glyph_text_blitter.sv
// Load request: busy stays low, no result. Render request: busy until its last row
// leaves the multiply stage, or not at all when there are no rows; each row passes
// the row sequencer, the fetch stage with the registered font store read, the multiply
// stage with the shared row multiplier and the result register, and one row follows
// every cycle. Reset sets the configuration defaults and clears the text cursor; the
// font store keeps its contents. Results cannot be stalled by the receiver.
`include "glyph_text_blitter_macros.svh"

module glyph_text_blitter #(
  parameter int MAX_GLYPH_ROWS = 16,
  parameter int GLYPH_CODES    = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [7:0]  char_code,
  input  logic [3:0]  glyph_row,
  input  logic [7:0]  glyph_bits,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [15:0] color,
  input  logic        restart_cursor,
  output logic        strobe,
  output logic [31:0] word_address,
  output logic [15:0] pixel_color,
  output logic [7:0]  write_mask,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int DEPTH  = GLYPH_CODES * MAX_GLYPH_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [4:0] ROW_CAP =
    5'((MAX_GLYPH_ROWS < gtb_pkg::ROW_LIMIT) ? MAX_GLYPH_ROWS : gtb_pkg::ROW_LIMIT);

  logic [15:0] fb_width, fb_height, line_stride;
  logic [3:0]  glyph_cols;
  logic [4:0]  glyph_rows;

  logic [15:0] text_cursor;
  logic [15:0] cursor_sel;

  gtb_pkg::state_t state;
  logic [3:0]  row;
  logic [4:0]  rows_q;
  logic [4:0]  rows_eff;
  logic [7:0]  code_q;
  logic        code_oob;
  logic [15:0] py_q;
  logic [15:0] color_q;
  logic [15:0] cur_q;

  logic [7:0]  font_mem [DEPTH];
  logic [7:0]  rd_data;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic        wr_en;

  gtb_pkg::fetch_stage_t s1;
  logic        s2_valid, s2_last;
  logic [31:0] s2_prod;
  logic [7:0]  s2_mask;
  logic [7:0]  mask_next;

  logic accept;
  logic render_go;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = (state != gtb_pkg::ST_IDLE) || s1.valid || s2_valid;

  always_comb begin
    rows_eff = glyph_rows;
    if (rows_eff > ROW_CAP) begin
      rows_eff = ROW_CAP;
    end
  end

  assign cursor_sel = restart_cursor ? pos_x : text_cursor;
  assign render_go  = accept && (func == gtb_pkg::FUNC_RENDER) && (rows_eff != 5'd0);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fb_width    <= gtb_pkg::RST_FB_WIDTH;
      fb_height   <= gtb_pkg::RST_FB_HEIGHT;
      line_stride <= gtb_pkg::RST_LINE_STRIDE;
      glyph_cols  <= gtb_pkg::RST_GLYPH_COLS;
      glyph_rows  <= gtb_pkg::RST_GLYPH_ROWS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gtb_pkg::CFG_FB_WIDTH:    fb_width    <= cfg_data;
        gtb_pkg::CFG_FB_HEIGHT:   fb_height   <= cfg_data;
        gtb_pkg::CFG_LINE_STRIDE: line_stride <= cfg_data;
        gtb_pkg::CFG_GLYPH_COLS:  glyph_cols  <= cfg_data[3:0];
        gtb_pkg::CFG_GLYPH_ROWS:  glyph_rows  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // The cursor moves on as soon as a character is taken, even with no rows.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_cursor <= '0;
    end else if (accept && (func == gtb_pkg::FUNC_RENDER)) begin
      text_cursor <= cursor_sel + 16'(glyph_cols);
    end
  end

  // Row sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gtb_pkg::ST_IDLE;
      row   <= '0;
    end else begin
      unique case (state)
        gtb_pkg::ST_IDLE: begin
          row <= '0;
          if (render_go) begin
            state <= gtb_pkg::ST_ISSUE;
          end
        end
        gtb_pkg::ST_ISSUE: begin
          row <= row + 4'd1;
          if (5'(row) + 5'd1 == rows_q) begin
            state <= gtb_pkg::ST_IDLE;
          end
        end
        default: state <= gtb_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (render_go) begin
      rows_q   <= rows_eff;
      code_q   <= char_code;
      code_oob <= 9'(char_code) >= 9'(GLYPH_CODES);
      py_q     <= pos_y;
      color_q  <= color;
      cur_q    <= cursor_sel;
    end
  end

  // Font store: one write port for loads, one registered read port for renders.
  assign wr_addr = ADDR_W'(32'(char_code) * MAX_GLYPH_ROWS + 32'(glyph_row));
  assign rd_addr = ADDR_W'(32'(code_q) * MAX_GLYPH_ROWS + 32'(row));
  assign wr_en   = accept && (func == gtb_pkg::FUNC_LOAD)
                   && (9'(char_code) < 9'(GLYPH_CODES))
                   && (6'(glyph_row) < 6'(MAX_GLYPH_ROWS));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      font_mem[wr_addr] <= glyph_bits;
    end
    rd_data <= font_mem[rd_addr];
  end

  // Fetch stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= (state == gtb_pkg::ST_ISSUE);
    end
    s1.y     <= py_q + 16'(row);
    s1.last  <= (5'(row) + 5'd1 == rows_q);
    s1.blank <= code_oob;
  end

  // Column mask: glyph bit, known character code, inside glyph width, inside framebuffer.
  always_comb begin
    logic [16:0] x;
    mask_next = '0;
    for (int c = 0; c < gtb_pkg::GLYPH_BITS; c++) begin
      x = {1'b0, cur_q} + 17'(c);
      mask_next[c] = ((rd_data & (gtb_pkg::LEFT_BIT >> c)) != 8'd0)
                     && !s1.blank
                     && (4'(c) < glyph_cols)
                     && !x[16]
                     && (x[15:0] < fb_width)
                     && (s1.y < fb_height);
    end
  end

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1.valid;
    end
    s2_prod <= 32'(s1.y) * 32'(line_stride);
    s2_mask <= mask_next;
    s2_last <= s1.last;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= s2_valid;
    end
    word_address <= s2_prod + 32'(cur_q);
    pixel_color  <= color_q;
    write_mask   <= s2_mask;
    last         <= s2_last;
  end

  `GTB_ASSERT_RST(a_gap_after_last, clk, rst, strobe && last |=> !strobe, "result right after last row")
  `GTB_ASSERT_RST(a_render_starts, clk, rst, render_go |=> state == gtb_pkg::ST_ISSUE, "render did not start")
  `GTB_ASSERT_RST(a_row_bound, clk, rst, state == gtb_pkg::ST_ISSUE |-> 5'(row) < rows_q, "row past count")
  `GTB_ASSERT_RST(a_strobe_source, clk, rst, strobe |-> $past(s1.valid, 2), "result without fetch")
  `GTB_ASSERT(a_reset_idle, clk, $past(rst) |-> !strobe, "result during reset")

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int CODE_COUNT = 256;
  localparam int STALL_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [31:0] word_address;
    logic [15:0] pixel_color;
    logic [7:0]  write_mask;
    logic        last;
  } row_write_t;

  typedef struct {
    logic [15:0] fb_width;
    logic [15:0] fb_height;
    logic [15:0] line_stride;
    logic [3:0]  glyph_cols;
    logic [4:0]  glyph_rows;
    int          idle_pct;
  } geometry_t;

  class glyph_row_scoreboard;
    logic [7:0]  font_rows [CODE_COUNT][gtb_pkg::ROW_LIMIT];
    logic [15:0] text_cursor;
    logic [15:0] fb_width;
    logic [15:0] fb_height;
    logic [15:0] line_stride;
    logic [3:0]  glyph_cols;
    logic [4:0]  glyph_rows;
    row_write_t  pending [$];
    int          errors;
    int          rows_checked;

    function new();
      text_cursor = '0;
      fb_width = gtb_pkg::RST_FB_WIDTH;
      fb_height = gtb_pkg::RST_FB_HEIGHT;
      line_stride = gtb_pkg::RST_LINE_STRIDE;
      glyph_cols = gtb_pkg::RST_GLYPH_COLS;
      glyph_rows = gtb_pkg::RST_GLYPH_ROWS;
      errors = 0;
      rows_checked = 0;
    endfunction

    function void set_register(logic [2:0] index, logic [15:0] data);
      case (index)
        gtb_pkg::CFG_FB_WIDTH: fb_width = data;
        gtb_pkg::CFG_FB_HEIGHT: fb_height = data;
        gtb_pkg::CFG_LINE_STRIDE: line_stride = data;
        gtb_pkg::CFG_GLYPH_COLS: glyph_cols = data[3:0];
        gtb_pkg::CFG_GLYPH_ROWS: glyph_rows = data[4:0];
        default: ;
      endcase
    endfunction

    // A load request fills one font byte; a render request queues one write per glyph row.
    function void note_request(logic kind, logic [7:0] code, logic [3:0] row_sel,
                               logic [7:0] bits, logic [15:0] px, logic [15:0] py,
                               logic [15:0] colr, logic restart);
      int          n_rows;
      int          n_cols;
      logic [15:0] y;
      logic [16:0] x;
      logic [7:0]  g;
      row_write_t  w;
      if (kind == gtb_pkg::FUNC_LOAD) begin
        font_rows[code][row_sel] = bits;
        return;
      end
      if (restart) text_cursor = px;
      n_rows = int'(glyph_rows);
      if (n_rows > gtb_pkg::ROW_LIMIT) n_rows = gtb_pkg::ROW_LIMIT;
      n_cols = int'(glyph_cols);
      if (n_cols > gtb_pkg::GLYPH_BITS) n_cols = gtb_pkg::GLYPH_BITS;
      for (int r = 0; r < n_rows; r++) begin
        y = py + 16'(r);
        g = font_rows[code][r];
        w.write_mask = '0;
        if (y < fb_height) begin
          for (int c = 0; c < n_cols; c++) begin
            // Pixels that run past the 16-bit column range are dropped, not wrapped.
            x = {1'b0, text_cursor} + 17'(c);
            if ((g & (gtb_pkg::LEFT_BIT >> c)) != 8'h00 && x[16] == 1'b0
                && x < {1'b0, fb_width})
              w.write_mask[c] = 1'b1;
          end
        end
        w.word_address = {16'b0, y} * {16'b0, line_stride} + {16'b0, text_cursor};
        w.pixel_color = colr;
        w.last = (r == n_rows - 1);
        pending.push_back(w);
      end
      text_cursor = text_cursor + {12'b0, glyph_cols};
    endfunction

    function void check_row_write(row_write_t got);
      row_write_t want;
      if (pending.size() == 0) begin
        $display("%0t: row write with none expected: address %h mask %h", $time,
                 got.word_address, got.write_mask);
        errors++;
        return;
      end
      want = pending.pop_front();
      rows_checked++;
      if (got.word_address !== want.word_address) begin
        $display("%0t: word_address expected %h got %h", $time, want.word_address,
                 got.word_address);
        errors++;
      end
      if (got.pixel_color !== want.pixel_color) begin
        $display("%0t: pixel_color expected %h got %h", $time, want.pixel_color,
                 got.pixel_color);
        errors++;
      end
      if (got.write_mask !== want.write_mask) begin
        $display("%0t: write_mask expected %b got %b", $time, want.write_mask, got.write_mask);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %b got %b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic        func;
  logic [7:0]  char_code;
  logic [3:0]  glyph_row;
  logic [7:0]  glyph_bits;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] color;
  logic        restart_cursor;
  logic        strobe;
  logic [31:0] word_address;
  logic [15:0] pixel_color;
  logic [7:0]  write_mask;
  logic        last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  glyph_row_scoreboard sb;
  geometry_t           cur;
  geometry_t           plan [6];
  logic [15:0]         rows_written [CODE_COUNT];
  logic [7:0]          defined_codes [$];
  int                  accept_count = 0;
  int                  cfg_count = 0;
  int                  idle_cycles = 0;
  int                  sender_idle_pct = 0;
  int                  load_count = 0;
  int                  render_count = 0;
  int                  setting_count = 0;

  glyph_text_blitter dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        sb.note_request(func, char_code, glyph_row, glyph_bits, pos_x, pos_y, color,
                        restart_cursor);
        accept_count <= accept_count + 1;
      end
      if (strobe) sb.check_row_write({word_address, pixel_color, write_mask, last});
      if (cfg_valid && cfg_ready) begin
        sb.set_register(cfg_index, cfg_data);
        cfg_count <= cfg_count + 1;
      end
    end
    if ((start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no request, result or register write for %0d cycles", $time, idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic geometry_t geometry(logic [15:0] w, logic [15:0] h, logic [15:0] s,
                                         logic [3:0] c, logic [4:0] r, int idle);
    geometry_t g;
    g.fb_width = w;
    g.fb_height = h;
    g.line_stride = s;
    g.glyph_cols = c;
    g.glyph_rows = r;
    g.idle_pct = idle;
    return g;
  endfunction

  // Half the time near the clip edge or the 16-bit wrap, where the mask logic is busiest.
  function automatic logic [15:0] pick_coord(logic [15:0] span);
    int v;
    case ($urandom_range(3))
      0: v = int'($urandom_range(65535));
      1: v = int'($urandom_range(65535, 65520));
      2: v = int'(span) - 4 + int'($urandom_range(8));
      default: v = int'($urandom_range(int'(span) + 8));
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken,
  // with start still high so that the next request can follow without a gap.
  task automatic send_request(logic kind, logic [7:0] code, logic [3:0] row_sel,
                              logic [7:0] bits, logic [15:0] px, logic [15:0] py,
                              logic [15:0] colr, logic restart);
    int seen;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    seen = accept_count;
    start <= 1'b1;
    func <= kind;
    char_code <= code;
    glyph_row <= row_sel;
    glyph_bits <= bits;
    pos_x <= px;
    pos_y <= py;
    color <= colr;
    restart_cursor <= restart;
    do @(negedge clk); while (accept_count == seen);
  endtask

  task automatic load_glyph_row(logic [7:0] code, logic [3:0] row_sel, logic [7:0] bits);
    send_request(gtb_pkg::FUNC_LOAD, code, row_sel, bits, 16'($urandom), 16'($urandom),
                 16'($urandom), 1'($urandom));
    load_count++;
    if (rows_written[code] != 16'hFFFF) begin
      rows_written[code][row_sel] = 1'b1;
      if (rows_written[code] == 16'hFFFF) defined_codes.push_back(code);
    end
  endtask

  task automatic render_char(logic [7:0] code, logic [15:0] px, logic [15:0] py,
                             logic [15:0] colr, logic restart);
    send_request(gtb_pkg::FUNC_RENDER, code, 4'($urandom), 8'($urandom), px, py, colr,
                 restart);
    render_count++;
  endtask

  task automatic define_glyph(logic [7:0] code);
    for (int r = 0; r < gtb_pkg::ROW_LIMIT; r++) load_glyph_row(code, 4'(r), 8'($urandom));
  endtask

  // Only fully loaded glyphs are rendered, so no unwritten font byte is ever read.
  task automatic random_item();
    logic [7:0] code;
    if (defined_codes.size() == 0 || $urandom_range(99) < 25) begin
      if (defined_codes.size() != 0 && $urandom_range(1) == 1)
        code = defined_codes[$urandom_range(defined_codes.size() - 1)];
      else
        code = 8'($urandom);
      load_glyph_row(code, 4'($urandom), 8'($urandom));
    end else begin
      code = defined_codes[$urandom_range(defined_codes.size() - 1)];
      render_char(code, pick_coord(cur.fb_width), pick_coord(cur.fb_height), 16'($urandom),
                  1'($urandom_range(99) < 30));
    end
  endtask

  // A render of zero rows gives no result, so allow for the pipeline to drain.
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_register(logic [2:0] index, logic [15:0] data);
    int seen;
    seen = cfg_count;
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(negedge clk); while (cfg_count == seen);
  endtask

  task automatic set_geometry(geometry_t g);
    wait_idle();
    write_register(gtb_pkg::CFG_FB_WIDTH, g.fb_width);
    write_register(gtb_pkg::CFG_FB_HEIGHT, g.fb_height);
    write_register(gtb_pkg::CFG_LINE_STRIDE, g.line_stride);
    write_register(gtb_pkg::CFG_GLYPH_COLS, {12'b0, g.glyph_cols});
    write_register(gtb_pkg::CFG_GLYPH_ROWS, {11'b0, g.glyph_rows});
    cfg_valid <= 1'b0;
    cur = g;
    sender_idle_pct = g.idle_pct;
    setting_count++;
  endtask

  initial begin
    sb = new();
    foreach (rows_written[i]) rows_written[i] = '0;
    rst = 1'b1;
    start = 1'b0;
    func = gtb_pkg::FUNC_LOAD;
    char_code = '0;
    glyph_row = '0;
    glyph_bits = '0;
    pos_x = '0;
    pos_y = '0;
    color = '0;
    restart_cursor = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = gtb_pkg::CFG_FB_WIDTH;
    cfg_data = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Small screen, four-row glyphs: clipping on every side is easy to reach.
    set_geometry(geometry(16'd64, 16'd32, 16'd100, 4'd8, 5'd4, 0));
    load_glyph_row(8'h00, 4'd0, 8'hFF);
    load_glyph_row(8'h00, 4'd1, 8'h81);
    load_glyph_row(8'h00, 4'd2, 8'h00);
    load_glyph_row(8'h00, 4'd3, 8'h3C);
    load_glyph_row(8'hFF, 4'd0, 8'h55);
    load_glyph_row(8'hFF, 4'd1, 8'hAA);
    load_glyph_row(8'hFF, 4'd2, 8'hFF);
    load_glyph_row(8'hFF, 4'd3, 8'h01);
    load_glyph_row(8'h5A, 4'd15, 8'h00);
    render_char(8'h00, 16'd0, 16'd0, 16'h0000, 1'b1);
    // Continues the text at x = 8; the lower two rows fall below the screen.
    render_char(8'hFF, 16'hFFFF, 16'd30, 16'hFFFF, 1'b0);
    render_char(8'h00, 16'd60, 16'd5, 16'h1234, 1'b1);
    // Both the row and the column run past 16 bits.
    render_char(8'hFF, 16'hFFFC, 16'hFFFE, 16'hA5A5, 1'b1);
    render_char(8'h00, 16'h0000, 16'd12, 16'h5A5A, 1'b0);
    // Glyphs wider than the mask still advance the cursor by the full width.
    set_geometry(geometry(16'd64, 16'd32, 16'd100, 4'd15, 5'd4, 0));
    render_char(8'hFF, 16'd10, 16'd0, 16'h00FF, 1'b1);
    render_char(8'h00, 16'd0, 16'd16, 16'hFF00, 1'b0);
    // With no rows the character makes no writes but the cursor moves on.
    set_geometry(geometry(16'd64, 16'd32, 16'd100, 4'd15, 5'd0, 0));
    render_char(8'h00, 16'd0, 16'd0, 16'h0F0F, 1'b0);
    render_char(8'hFF, 16'd0, 16'd0, 16'hF0F0, 1'b0);

    plan[0] = geometry(gtb_pkg::RST_FB_WIDTH, gtb_pkg::RST_FB_HEIGHT,
                       gtb_pkg::RST_LINE_STRIDE, gtb_pkg::RST_GLYPH_COLS,
                       gtb_pkg::RST_GLYPH_ROWS, 0);
    plan[1] = geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 5'h1F, 82);
    plan[2] = geometry(16'h0000, 16'h0000, 16'h0000, 4'h0, 5'h00, 0);
    plan[3] = geometry(16'd100, 16'd50, 16'd128, 4'd5, 5'd7, 15);
    plan[4] = geometry(16'($urandom_range(400, 16)), 16'($urandom_range(300, 16)),
                       16'($urandom), 4'($urandom_range(8, 1)), 5'($urandom_range(16, 1)),
                       82);
    plan[5] = geometry(16'd40, 16'd20, 16'd40, 4'd6, 5'd16, 0);
    for (int p = 0; p < 6; p++) begin
      set_geometry(plan[p]);
      if (p == 0) repeat (3) define_glyph(8'($urandom));
      repeat (9) random_item();
    end
    wait_idle();

    $display("Sent %0d glyph loads and %0d character renders under %0d register settings;",
             load_count, render_count, setting_count);
    $display("checked %0d row writes, %0d mismatches.", sb.rows_checked, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
